FILE: hw/rtl/fk_pkg.sv
// ----------------------------------------------------------------------------
// fk_pkg
// Shared types and constants of the planar three-link forward kinematics unit.
// ----------------------------------------------------------------------------
package fk_pkg;

  localparam int unsigned ANGLE_BITS_DEF  = 16;
  localparam int unsigned LENGTH_BITS_DEF = 16;

  localparam int unsigned NUM_LINKS   = 3;
  localparam int unsigned TRIG_W      = 16;  // Q2.14
  localparam int unsigned POS_W       = 19;  // Q11.8
  localparam int unsigned LANE_STAGES = 6;
  localparam int unsigned MERGE_STAGES = 2;
  localparam int unsigned PIPE_STAGES = LANE_STAGES + MERGE_STAGES;

  // quarter-wave sine polynomial, Q16
  localparam logic [16:0] POLY_A = 17'd102944;
  localparam logic [15:0] POLY_B = 16'd42048;   // 2A - 163840
  localparam logic [12:0] POLY_C = 13'd4640;    // A - 98304

  localparam int unsigned LEN_RESET = 256;      // 1.0 in Q8.8
  localparam int unsigned ROUND_Q22 = 8192;

  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 4;

  typedef enum logic [1:0] {
    REG_LINK1 = 2'd0,
    REG_LINK2 = 2'd1,
    REG_LINK3 = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  typedef logic signed [TRIG_W-1:0] trig_t;

endpackage

FILE: hw/rtl/fk_sincos.sv
// ----------------------------------------------------------------------------
// fk_sincos
// One lane: binary angle to Q2.14 sine and cosine, six register stages.
// ----------------------------------------------------------------------------
module fk_sincos #(
  parameter int unsigned ANGLE_BITS = fk_pkg::ANGLE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic [fk_pkg::LANE_STAGES-1:0]        en_i,
  input  logic [ANGLE_BITS-1:0]                 angle_i,
  output fk_pkg::trig_t                         sin_o,
  output fk_pkg::trig_t                         cos_o
);

  localparam int unsigned PAD = 32 - ANGLE_BITS;

  logic [31:0] phase;
  logic [15:0] frac;

  // stage registers: s = sine path, c = cosine path
  logic [1:0]  quad1_q, quad2_q, quad3_q, quad4_q, quad5_q;
  logic [16:0] us1_q, uc1_q, us2_q, uc2_q, us3_q, uc3_q, us4_q, uc4_q;
  logic [16:0] u2s2_q, u2c2_q, u2s3_q, u2c3_q;
  logic [13:0] t1s3_q, t1c3_q;
  logic [16:0] t2s4_q, t2c4_q;
  logic [17:0] t3s5_q, t3c5_q;
  fk_pkg::trig_t sin_q, cos_q;

  logic [33:0] sq_s, sq_c, pc_s, pc_c, pb_s, pb_c, pa_s, pa_c;
  logic [16:0] bs, bc;
  logic [17:0] as_, ac;
  logic [18:0] rnd_s, rnd_c;
  fk_pkg::trig_t mag_s, mag_c;
  fk_pkg::trig_t sin_d, cos_d;

  assign phase = {angle_i, {PAD{1'b0}}};
  assign frac  = phase[29:14];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      quad1_q <= phase[31:30];
      us1_q   <= {1'b0, frac};
      uc1_q   <= 17'h10000 - {1'b0, frac};
    end
  end

  // u^2
  assign sq_s = 34'(us1_q) * 34'(us1_q);
  assign sq_c = 34'(uc1_q) * 34'(uc1_q);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      quad2_q <= quad1_q;
      us2_q   <= us1_q;
      uc2_q   <= uc1_q;
      u2s2_q  <= sq_s[32:16];
      u2c2_q  <= sq_c[32:16];
    end
  end

  // C * u^2
  assign pc_s = 34'(fk_pkg::POLY_C) * 34'(u2s2_q);
  assign pc_c = 34'(fk_pkg::POLY_C) * 34'(u2c2_q);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      quad3_q <= quad2_q;
      us3_q   <= us2_q;
      uc3_q   <= uc2_q;
      u2s3_q  <= u2s2_q;
      u2c3_q  <= u2c2_q;
      t1s3_q  <= pc_s[29:16];
      t1c3_q  <= pc_c[29:16];
    end
  end

  // (B - t) * u^2
  assign bs   = 17'(fk_pkg::POLY_B) - 17'(t1s3_q);
  assign bc   = 17'(fk_pkg::POLY_B) - 17'(t1c3_q);
  assign pb_s = 34'(bs) * 34'(u2s3_q);
  assign pb_c = 34'(bc) * 34'(u2c3_q);

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      quad4_q <= quad3_q;
      us4_q   <= us3_q;
      uc4_q   <= uc3_q;
      t2s4_q  <= pb_s[32:16];
      t2c4_q  <= pb_c[32:16];
    end
  end

  // (A - t) * u
  assign as_  = 18'(fk_pkg::POLY_A) - 18'(t2s4_q);
  assign ac   = 18'(fk_pkg::POLY_A) - 18'(t2c4_q);
  assign pa_s = 34'(as_) * 34'(us4_q);
  assign pa_c = 34'(ac) * 34'(uc4_q);

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      quad5_q <= quad4_q;
      t3s5_q  <= pa_s[33:16];
      t3c5_q  <= pa_c[33:16];
    end
  end

  // Q16 -> Q14 with rounding, then fold by quadrant
  assign rnd_s = 19'(t3s5_q) + 19'd2;
  assign rnd_c = 19'(t3c5_q) + 19'd2;
  assign mag_s = fk_pkg::trig_t'(rnd_s[18:2]);
  assign mag_c = fk_pkg::trig_t'(rnd_c[18:2]);

  always_comb begin
    unique case (fk_pkg::quad_e'(quad5_q))
      fk_pkg::QUAD_0: begin
        sin_d = mag_s;
        cos_d = mag_c;
      end
      fk_pkg::QUAD_1: begin
        sin_d = mag_c;
        cos_d = -mag_s;
      end
      fk_pkg::QUAD_2: begin
        sin_d = -mag_s;
        cos_d = -mag_c;
      end
      fk_pkg::QUAD_3: begin
        sin_d = -mag_c;
        cos_d = mag_s;
      end
      default: begin
        sin_d = mag_s;
        cos_d = mag_c;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

FILE: hw/rtl/fk_merge.sv
// ----------------------------------------------------------------------------
// fk_merge
// Scales each lane by its link length, sums the lanes, rounds and saturates to Q11.8.
// ----------------------------------------------------------------------------
module fk_merge #(
  parameter int unsigned LENGTH_BITS = fk_pkg::LENGTH_BITS_DEF
) (
  input  logic                                     clk_i,
  input  logic [fk_pkg::MERGE_STAGES-1:0]          en_i,
  input  logic [fk_pkg::NUM_LINKS-1:0][LENGTH_BITS-1:0] len_i,
  input  fk_pkg::trig_t [fk_pkg::NUM_LINKS-1:0]    cos_i,
  input  fk_pkg::trig_t [fk_pkg::NUM_LINKS-1:0]    sin_i,
  output logic signed [fk_pkg::POS_W-1:0]          tip_x_o,
  output logic signed [fk_pkg::POS_W-1:0]          tip_y_o,
  output fk_pkg::trig_t                            heading_cos_o,
  output fk_pkg::trig_t                            heading_sin_o
);

  localparam int unsigned PROD_W = LENGTH_BITS + fk_pkg::TRIG_W + 1;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam logic signed [SUM_W-1:0] PMAX = SUM_W'((2 ** (fk_pkg::POS_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] PMIN = -SUM_W'(2 ** (fk_pkg::POS_W - 1));

  logic signed [PROD_W-1:0] px_q [fk_pkg::NUM_LINKS];
  logic signed [PROD_W-1:0] py_q [fk_pkg::NUM_LINKS];
  fk_pkg::trig_t hc_q, hs_q;

  logic signed [SUM_W-1:0] sum_x, sum_y, rx, ry;
  logic signed [fk_pkg::POS_W-1:0] sat_x, sat_y;
  logic signed [fk_pkg::POS_W-1:0] tip_x_q, tip_y_q;
  fk_pkg::trig_t hc_out_q, hs_out_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int i = 0; i < fk_pkg::NUM_LINKS; i++) begin
        px_q[i] <= PROD_W'($signed({1'b0, len_i[i]})) * PROD_W'(cos_i[i]);
        py_q[i] <= PROD_W'($signed({1'b0, len_i[i]})) * PROD_W'(sin_i[i]);
      end
      hc_q <= cos_i[fk_pkg::NUM_LINKS-1];
      hs_q <= sin_i[fk_pkg::NUM_LINKS-1];
    end
  end

  always_comb begin
    sum_x = '0;
    sum_y = '0;
    for (int i = 0; i < fk_pkg::NUM_LINKS; i++) begin
      sum_x = sum_x + SUM_W'(px_q[i]);
      sum_y = sum_y + SUM_W'(py_q[i]);
    end
    // Q22 -> Q11.8, halves toward plus infinity
    rx = (sum_x + $signed(SUM_W'(fk_pkg::ROUND_Q22))) >>> 14;
    ry = (sum_y + $signed(SUM_W'(fk_pkg::ROUND_Q22))) >>> 14;
    priority if (rx > PMAX) sat_x = PMAX[fk_pkg::POS_W-1:0];
    else if (rx < PMIN)     sat_x = PMIN[fk_pkg::POS_W-1:0];
    else                    sat_x = rx[fk_pkg::POS_W-1:0];
    priority if (ry > PMAX) sat_y = PMAX[fk_pkg::POS_W-1:0];
    else if (ry < PMIN)     sat_y = PMIN[fk_pkg::POS_W-1:0];
    else                    sat_y = ry[fk_pkg::POS_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      tip_x_q  <= sat_x;
      tip_y_q  <= sat_y;
      hc_out_q <= hc_q;
      hs_out_q <= hs_q;
    end
  end

  assign tip_x_o       = tip_x_q;
  assign tip_y_o       = tip_y_q;
  assign heading_cos_o = hc_out_q;
  assign heading_sin_o = hs_out_q;

endmodule

FILE: hw/rtl/planar_three_link_forward_kinematics_unit.sv
// Eight register stages lie between the accepting edge and m_axis_tvalid.
// Throughput: one item per cycle unless the output stalls; each stage holds its
// item only while the stage after it is full and stalled, so bubbles collapse
// and the input is taken while a result waits at the output if a stage is empty.
// Reset empties the pipeline and sets all three link lengths to 1.0.
// ----------------------------------------------------------------------------
// planar_three_link_forward_kinematics_unit
// Three trig lanes (one per cumulative joint angle) and a merge unit that
// forms the tip position and the total heading of a planar 3R arm.
// ----------------------------------------------------------------------------
module planar_three_link_forward_kinematics_unit #(
  parameter int unsigned ANGLE_BITS  = fk_pkg::ANGLE_BITS_DEF,
  parameter int unsigned LENGTH_BITS = fk_pkg::LENGTH_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // joint1_angle, joint2_angle, joint3_angle, zero pad
  input  logic [((3*ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tip_x[18:0], tip_y[37:19], heading_cos[53:38], heading_sin[69:54], zero pad
  output logic [71:0]                      m_axis_tdata,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fk_pkg::APB_AW-1:0]        paddr,
  input  logic [fk_pkg::APB_DW-1:0]        pwdata,
  output logic [fk_pkg::APB_DW-1:0]        prdata,
  output logic                             pready
);

  localparam int unsigned NS = fk_pkg::PIPE_STAGES;
  localparam int unsigned NL = fk_pkg::NUM_LINKS;

  // ---------------- configuration ----------------
  logic [NL-1:0][LENGTH_BITS-1:0] len_q;
  fk_pkg::reg_idx_e reg_idx;
  logic cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = fk_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NL; i++) len_q[i] <= LENGTH_BITS'(fk_pkg::LEN_RESET);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        fk_pkg::REG_LINK1: len_q[0] <= pwdata[LENGTH_BITS-1:0];
        fk_pkg::REG_LINK2: len_q[1] <= pwdata[LENGTH_BITS-1:0];
        fk_pkg::REG_LINK3: len_q[2] <= pwdata[LENGTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      fk_pkg::REG_LINK1: prdata = fk_pkg::APB_DW'(len_q[0]);
      fk_pkg::REG_LINK2: prdata = fk_pkg::APB_DW'(len_q[1]);
      fk_pkg::REG_LINK3: prdata = fk_pkg::APB_DW'(len_q[2]);
      default:           prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic [NS-1:0] vld_q, vld_d, rdy;

  always_comb begin
    rdy[NS-1] = !vld_q[NS-1] || m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) rdy[k] = !vld_q[k] || rdy[k+1];
    vld_d[0] = rdy[0] ? s_axis_tvalid : vld_q[0];
    for (int k = 1; k < NS; k++) vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[NS-1];

  // ---------------- cumulative angles ----------------
  logic [NL-1:0][ANGLE_BITS-1:0] cum;

  assign cum[0] = s_axis_tdata[ANGLE_BITS-1:0];
  assign cum[1] = cum[0] + s_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS];
  assign cum[2] = cum[1] + s_axis_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS];

  // ---------------- trig lanes ----------------
  fk_pkg::trig_t [NL-1:0] lane_sin, lane_cos;

  for (genvar g = 0; g < NL; g++) begin : g_lane
    fk_sincos #(
      .ANGLE_BITS(ANGLE_BITS)
    ) u_sincos (
      .clk_i  (clk_i),
      .en_i   (rdy[fk_pkg::LANE_STAGES-1:0]),
      .angle_i(cum[g]),
      .sin_o  (lane_sin[g]),
      .cos_o  (lane_cos[g])
    );
  end

  // ---------------- merge ----------------
  logic signed [fk_pkg::POS_W-1:0] tip_x, tip_y;
  fk_pkg::trig_t hd_cos, hd_sin;

  fk_merge #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_merge (
    .clk_i        (clk_i),
    .en_i         (rdy[NS-1:fk_pkg::LANE_STAGES]),
    .len_i        (len_q),
    .cos_i        (lane_cos),
    .sin_i        (lane_sin),
    .tip_x_o      (tip_x),
    .tip_y_o      (tip_y),
    .heading_cos_o(hd_cos),
    .heading_sin_o(hd_sin)
  );

  assign m_axis_tdata = {2'b00, hd_sin, hd_cos, tip_y, tip_x};

endmodule
